// ===== rtl/pes_header_timestamp_parser_assert.svh =====
// Assertion macros used by the checker file of the PES timestamp parser.
`ifndef PES_HEADER_TIMESTAMP_PARSER_ASSERT_SVH
`define PES_HEADER_TIMESTAMP_PARSER_ASSERT_SVH

// Concurrent assertion, muted while reset is held.
`define PHTS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Concurrent assertion that is also checked across reset.
`define PHTS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/phts_pkg.sv =====
// ----------------------------------------------------------------------------
// PES timestamp parser package
// Shared widths, constants, stage structs and the stamp decode function.
// ----------------------------------------------------------------------------
package phts_pkg;

    localparam int STAMP_W  = 33;
    localparam int RAW_W    = 40;
    localparam int IDX_W    = 9;
    localparam int OFF_W    = 9;
    localparam int TDATA_W  = 80;

    localparam logic [STAMP_W-1:0] GAP_RESET = 33'd180000;
    localparam logic [IDX_W-1:0]   IDX_MAX   = '1;

    // Byte positions inside the PES header
    localparam logic [IDX_W-1:0] IDX_MARKER   = 9'd6;
    localparam logic [IDX_W-1:0] IDX_FLAGS    = 9'd7;
    localparam logic [IDX_W-1:0] IDX_HDR_LEN  = 9'd8;
    localparam logic [IDX_W-1:0] IDX_PTS_LO   = 9'd9;
    localparam logic [IDX_W-1:0] IDX_PTS_HI   = 9'd13;
    localparam logic [IDX_W-1:0] IDX_DTS_LO   = 9'd14;
    localparam logic [IDX_W-1:0] IDX_DTS_HI   = 9'd18;

    localparam logic [1:0] MARKER_OK   = 2'b10;
    localparam logic [1:0] KIND_PTS    = 2'b10;
    localparam logic [1:0] KIND_BOTH   = 2'b11;
    localparam logic [7:0] MIN_LEN_PTS  = 8'd5;
    localparam logic [7:0] MIN_LEN_BOTH = 8'd10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MARK  = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_SHORT_LEN = 2'd3
    } status_t;

    // Parser state handed to the stamp stage
    typedef struct packed {
        logic             fire;
        logic             trunc;
        logic [7:0]       marker;
        logic [7:0]       flags;
        logic [7:0]       hdr_len;
        logic [RAW_W-1:0] pts_bytes;
        logic [RAW_W-1:0] dts_bytes;
    } hdr_t;

    typedef struct packed {
        logic [OFF_W-1:0]   payload_offset;
        logic               dts_valid;
        logic               pts_valid;
        logic [STAMP_W-1:0] dts_value;
        logic [STAMP_W-1:0] pts_value;
        status_t            status;
    } result_t;

    typedef struct packed {
        logic               ok;
        logic [STAMP_W-1:0] value;
    } stamp_t;

    // Five bytes a,b1,b2,c1,c2 with marker bits in bit 0 of a, b2 and c2
    function automatic stamp_t decode_stamp(input logic [RAW_W-1:0] raw);
        stamp_t s;
        s.ok    = raw[32] & raw[16] & raw[0];
        s.value = s.ok ? {raw[35:33], raw[31:17], raw[15:1]} : '0;
        return s;
    endfunction

endpackage

// ===== rtl/phts_parser.sv =====
// ----------------------------------------------------------------------------
// PES header byte parser
// Tracks the byte position, captures header bytes and flags the header end.
// ----------------------------------------------------------------------------
module phts_parser
    import phts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic       advance,
    input  logic [7:0] byte_in,
    input  logic       first_in,
    input  logic       last_in,
    output hdr_t       hdr
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       marker_reg, marker_next;
    logic [7:0]       flags_reg, flags_next;
    logic [7:0]       len_reg, len_next;
    logic [RAW_W-1:0] pts_reg, pts_next;
    logic [RAW_W-1:0] dts_reg, dts_next;
    logic             done_reg, done_next;
    logic             fire_reg, fire_next;
    logic             trunc_reg, trunc_next;

    logic [IDX_W-1:0] cur_idx;
    logic             cur_done;
    logic             hdr_end;

    always_comb begin
        cur_idx     = first_in ? '0 : idx_reg;
        cur_done    = first_in ? 1'b0 : done_reg;
        marker_next = first_in ? '0 : marker_reg;
        flags_next  = first_in ? '0 : flags_reg;
        len_next    = first_in ? '0 : len_reg;
        pts_next    = first_in ? '0 : pts_reg;
        dts_next    = first_in ? '0 : dts_reg;
        idx_next    = cur_idx;
        done_next   = cur_done;
        hdr_end     = 1'b0;
        fire_next   = 1'b0;
        trunc_next  = 1'b0;

        if (!cur_done) begin
            if (cur_idx == IDX_MARKER) begin
                marker_next = byte_in;
            end else if (cur_idx == IDX_FLAGS) begin
                flags_next = byte_in;
            end else if (cur_idx == IDX_HDR_LEN) begin
                len_next = byte_in;
            end else if (cur_idx >= IDX_PTS_LO && cur_idx <= IDX_PTS_HI) begin
                pts_next = {pts_next[RAW_W-9:0], byte_in};
            end else if (cur_idx >= IDX_DTS_LO && cur_idx <= IDX_DTS_HI) begin
                dts_next = {dts_next[RAW_W-9:0], byte_in};
            end

            hdr_end    = (cur_idx >= IDX_HDR_LEN) &&
                         (cur_idx == IDX_HDR_LEN + {1'b0, len_next});
            fire_next  = hdr_end || (last_in && cur_idx >= IDX_HDR_LEN);
            trunc_next = !hdr_end;
            done_next  = hdr_end || last_in;
            if (cur_idx != IDX_MAX) begin
                idx_next = cur_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            marker_reg <= '0;
            flags_reg  <= '0;
            len_reg    <= '0;
            pts_reg    <= '0;
            dts_reg    <= '0;
            done_reg   <= 1'b1;
            fire_reg   <= 1'b0;
            trunc_reg  <= 1'b0;
        end else if (advance) begin
            // fire lasts one advance; state moves only on an accepted word
            fire_reg  <= accept && fire_next;
            trunc_reg <= trunc_next;
            if (accept) begin
                idx_reg    <= idx_next;
                marker_reg <= marker_next;
                flags_reg  <= flags_next;
                len_reg    <= len_next;
                pts_reg    <= pts_next;
                dts_reg    <= dts_next;
                done_reg   <= done_next;
            end
        end
    end

    assign hdr.fire      = fire_reg;
    assign hdr.trunc     = trunc_reg;
    assign hdr.marker    = marker_reg;
    assign hdr.flags     = flags_reg;
    assign hdr.hdr_len   = len_reg;
    assign hdr.pts_bytes = pts_reg;
    assign hdr.dts_bytes = dts_reg;

endmodule

// ===== rtl/phts_stamp_unit.sv =====
// ----------------------------------------------------------------------------
// PES stamp decode and result register
// Decodes PTS/DTS, checks the stamp gap and holds the result word.
// ----------------------------------------------------------------------------
module phts_stamp_unit
    import phts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  hdr_t               hdr,
    input  logic [STAMP_W-1:0] max_gap,
    output logic               res_valid,
    output result_t            res
);

    logic    valid_reg;
    result_t res_reg, res_next;
    stamp_t  pts_dec, dts_dec;
    logic [STAMP_W-1:0] gap;
    logic    mark_ok;
    logic [1:0] kind;

    always_comb begin
        pts_dec  = decode_stamp(hdr.pts_bytes);
        dts_dec  = decode_stamp(hdr.dts_bytes);
        gap      = pts_dec.value - dts_dec.value;
        mark_ok  = (hdr.marker[7:6] == MARKER_OK);
        kind     = hdr.flags[7:6];
        res_next = '0;

        if (!mark_ok) begin
            res_next.status = ST_BAD_MARK;
        end else if (hdr.trunc) begin
            res_next.status = ST_TRUNC;
        end else if ((kind == KIND_BOTH && hdr.hdr_len < MIN_LEN_BOTH) ||
                     (kind == KIND_PTS && hdr.hdr_len < MIN_LEN_PTS)) begin
            res_next.status = ST_SHORT_LEN;
        end else begin
            res_next.status         = ST_OK;
            res_next.payload_offset = IDX_PTS_LO + {1'b0, hdr.hdr_len};
            if (kind == KIND_BOTH) begin
                // drop both stamps when the wrapped gap is out of range
                if (!(pts_dec.ok && dts_dec.ok && gap > max_gap)) begin
                    res_next.pts_valid = pts_dec.ok;
                    res_next.pts_value = pts_dec.value;
                    res_next.dts_valid = dts_dec.ok;
                    res_next.dts_value = dts_dec.value;
                end
            end else if (kind == KIND_PTS) begin
                res_next.pts_valid = pts_dec.ok;
                res_next.pts_value = pts_dec.value;
                res_next.dts_valid = pts_dec.ok;
                res_next.dts_value = pts_dec.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= hdr.fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && hdr.fire) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/pes_header_timestamp_parser.sv =====
// A result word is valid once the header-ending byte has passed the parser register and then the result register.
// Throughput: one byte per cycle; the two-stage pipe (parser register, result register)
// advances together and holds only while a result word waits on m_tready.
// Reset: synchronous, active low; parsing idles until a byte marked first,
// max_stamp_gap returns to 180000.
// ----------------------------------------------------------------------------
// PES header timestamp parser
// Extracts PTS/DTS and header status from a stream of PES packet bytes.
// ----------------------------------------------------------------------------
module pes_header_timestamp_parser
    import phts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] pes_byte
    input  logic [0:0]          s_tuser,   // [0] is_first
    input  logic                s_tlast,   // is_last
    output logic                m_tvalid,
    input  logic                m_tready,
    // [1:0] status, [34:2] pts_value, [67:35] dts_value, [68] pts_valid,
    // [69] dts_valid, [78:70] payload_offset, [79] zero
    output logic [TDATA_W-1:0]  m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [STAMP_W-1:0]  cfg_data   // max_stamp_gap
);

    logic               advance;
    logic               accept;
    logic [STAMP_W-1:0] max_gap_reg;
    hdr_t               hdr;
    result_t            res;

    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg <= GAP_RESET;
        end else if (cfg_valid) begin
            max_gap_reg <= cfg_data;
        end
    end

    phts_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .advance  (advance),
        .byte_in  (s_tdata),
        .first_in (s_tuser[0]),
        .last_in  (s_tlast),
        .hdr      (hdr)
    );

    phts_stamp_unit u_stamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .hdr       (hdr),
        .max_gap   (max_gap_reg),
        .res_valid (m_tvalid),
        .res       (res)
    );

    assign m_tdata = {1'b0, res};

endmodule

// ===== rtl/phts_checker.sv =====
// ----------------------------------------------------------------------------
// PES timestamp parser checker
// Port-level assertions on result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "pes_header_timestamp_parser_assert.svh"

module phts_checker
    import phts_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    logic err_word;
    logic ok_word;

    assign err_word = m_tvalid && (m_tdata[1:0] != ST_OK);
    assign ok_word  = m_tvalid && (m_tdata[1:0] == ST_OK);

    `PHTS_ASSERT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `PHTS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result word after reset")
    `PHTS_ASSERT(a_err_zero, aclk, aresetn, err_word |-> m_tdata[79:2] == '0, "error word carries stamps")
    `PHTS_ASSERT(a_ok_fields, aclk, aresetn, ok_word |-> m_tdata[78:70] >= 9'd9 && (m_tdata[68] || m_tdata[34:2] == '0) && (m_tdata[69] || m_tdata[67:35] == '0), "bad fields in ok word")

endmodule

bind pes_header_timestamp_parser phts_checker u_phts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
